>>> rtl/tbi_pkg.sv
// ----------------------------------------------------------------------------
// tbi_pkg
// Types, codes and the block kind table shared by the tape block indexer.
// ----------------------------------------------------------------------------
package tbi_pkg;

    localparam int unsigned OffsetWidth = 32;

    // Result status codes.
    localparam logic [1:0] ST_INDEXED  = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    // One input item.
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [1:0]             status;
        logic [OffsetWidth-1:0] offset;
        logic [7:0]             id;
    } t_result;

    // Layout of one known block kind.
    typedef struct packed {
        logic       known;
        logic [4:0] fixed;
        logic [2:0] len_bytes;
        logic [1:0] mult;
    } t_kind;

    function automatic t_kind kind_lookup(input logic [7:0] id);
        t_kind k;
        k = '{known: 1'b1, fixed: 5'd0, len_bytes: 3'd0, mult: 2'd1};
        unique case (id)
            8'h10: begin k.fixed = 5'd2;  k.len_bytes = 3'd2; end
            8'h11: begin k.fixed = 5'd15; k.len_bytes = 3'd3; end
            8'h12: begin k.fixed = 5'd4;                      end
            8'h13: begin k.len_bytes = 3'd1; k.mult = 2'd2;   end
            8'h14: begin k.fixed = 5'd7;  k.len_bytes = 3'd3; end
            8'h15: begin k.fixed = 5'd5;  k.len_bytes = 3'd3; end
            8'h18: begin k.len_bytes = 3'd4;                  end
            8'h19: begin k.len_bytes = 3'd4;                  end
            8'h20: begin k.fixed = 5'd2;                      end
            8'h21: begin k.len_bytes = 3'd1;                  end
            8'h22: begin                                      end
            8'h23: begin k.fixed = 5'd2;                      end
            8'h24: begin k.fixed = 5'd2;                      end
            8'h25: begin                                      end
            8'h26: begin k.len_bytes = 3'd2; k.mult = 2'd2;   end
            8'h27: begin                                      end
            8'h28: begin k.len_bytes = 3'd2;                  end
            8'h2a: begin k.fixed = 5'd4;                      end
            8'h2b: begin k.fixed = 5'd5;                      end
            8'h30: begin k.len_bytes = 3'd1;                  end
            8'h31: begin k.fixed = 5'd1;  k.len_bytes = 3'd1; end
            8'h32: begin k.len_bytes = 3'd2;                  end
            8'h33: begin k.len_bytes = 3'd1; k.mult = 2'd3;   end
            8'h35: begin k.fixed = 5'd16; k.len_bytes = 3'd4; end
            8'h5a: begin k.fixed = 5'd9;                      end
            default: begin k.known = 1'b0;                    end
        endcase
        return k;
    endfunction

endpackage

>>> rtl/tbi_in_reg.sv
// ----------------------------------------------------------------------------
// tbi_in_reg
// Input register that holds one stream item until the core consumes it.
// ----------------------------------------------------------------------------
module tbi_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tbi_pkg::t_item i_item,
    input  logic          i_out_free,
    output logic          o_fire,
    output tbi_pkg::t_item o_item
);
    import tbi_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The held item moves on whenever the result side has room.
    assign o_fire  = r_valid && i_out_free;
    assign o_ready = !r_valid || i_out_free;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/tbi_core.sv
// ----------------------------------------------------------------------------
// tbi_core
// Block walker: decodes IDs, skips fixed, length and payload bytes.
// ----------------------------------------------------------------------------
module tbi_core #(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  tbi_pkg::t_item   i_item,
    output logic             o_res_valid,
    output tbi_pkg::t_result o_res
);
    import tbi_pkg::*;

    localparam logic [2:0] PH_AWAIT   = 3'd0;
    localparam logic [2:0] PH_FIXED   = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    logic [2:0]                r_phase,    n_phase;
    logic [POSITION_WIDTH-1:0] r_pos,      n_pos;
    logic [4:0]                r_fixed,    n_fixed;
    logic [2:0]                r_len_left, n_len_left;
    logic [1:0]                r_shift,    n_shift;
    logic [31:0]               r_len_val,  n_len_val;
    logic [1:0]                r_mult,     n_mult;
    logic [31:0]               r_payload,  n_payload;

    t_kind       kind;
    logic [31:0] here;
    logic [31:0] val_next;
    logic [31:0] product;
    logic [4:0]  fixed_dec;
    logic [2:0]  len_dec;
    logic [31:0] payload_dec;

    assign kind        = kind_lookup(i_item.data);
    assign here        = 32'(r_pos);
    assign val_next    = r_len_val | (32'(i_item.data) << {r_shift, 3'b000});
    // Multiplier is 1 to 3, so the product is one shift and one add.
    assign product     = (r_mult[0] ? val_next : 32'd0) +
                         (r_mult[1] ? {val_next[30:0], 1'b0} : 32'd0);
    assign fixed_dec   = r_fixed - 5'd1;
    assign len_dec     = r_len_left - 3'd1;
    assign payload_dec = r_payload - 32'd1;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_fixed     = r_fixed;
        n_len_left  = r_len_left;
        n_shift     = r_shift;
        n_len_val   = r_len_val;
        n_mult      = r_mult;
        n_payload   = r_payload;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_ERROR, offset: here, id: 8'd0};

        if (i_fire) begin
            if (r_phase == PH_ERROR) begin
                o_res_valid = 1'b1;
            end else if (r_phase == PH_DONE) begin
                if (i_item.is_end) begin
                    o_res_valid  = 1'b1;
                    o_res.status = ST_COMPLETE;
                end
            end else if (i_item.is_end) begin
                o_res_valid = 1'b1;
                if (r_phase == PH_AWAIT) begin
                    n_phase      = PH_DONE;
                    o_res.status = ST_COMPLETE;
                end else begin
                    n_phase = PH_ERROR;
                end
            end else if (r_phase == PH_AWAIT) begin
                o_res_valid = 1'b1;
                o_res.id    = i_item.data;
                if (!kind.known) begin
                    n_phase = PH_ERROR;
                end else begin
                    o_res.status = ST_INDEXED;
                    n_pos        = r_pos + POSITION_WIDTH'(1);
                    n_fixed      = kind.fixed;
                    n_len_left   = kind.len_bytes;
                    n_shift      = 2'd0;
                    n_len_val    = 32'd0;
                    n_mult       = kind.mult;
                    n_payload    = 32'd0;
                    if (kind.fixed != 5'd0) begin
                        n_phase = PH_FIXED;
                    end else if (kind.len_bytes != 3'd0) begin
                        n_phase = PH_LENGTH;
                    end else begin
                        n_phase = PH_AWAIT;
                    end
                end
            end else begin
                n_pos = r_pos + POSITION_WIDTH'(1);
                unique case (r_phase)
                    PH_FIXED: begin
                        n_fixed = fixed_dec;
                        if (fixed_dec == 5'd0) begin
                            n_phase = (r_len_left != 3'd0) ? PH_LENGTH : PH_AWAIT;
                        end
                    end
                    PH_LENGTH: begin
                        n_len_val  = val_next;
                        n_shift    = r_shift + 2'd1;
                        n_len_left = len_dec;
                        if (len_dec == 3'd0) begin
                            n_payload = product;
                            n_phase   = (product != 32'd0) ? PH_PAYLOAD : PH_AWAIT;
                        end
                    end
                    default: begin
                        n_payload = payload_dec;
                        if (payload_dec == 32'd0) begin
                            n_phase = PH_AWAIT;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_AWAIT;
            r_pos      <= '0;
            r_fixed    <= 5'd0;
            r_len_left <= 3'd0;
            r_shift    <= 2'd0;
            r_len_val  <= 32'd0;
            r_mult     <= 2'd1;
            r_payload  <= 32'd0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_fixed    <= n_fixed;
            r_len_left <= n_len_left;
            r_shift    <= n_shift;
            r_len_val  <= n_len_val;
            r_mult     <= n_mult;
            r_payload  <= n_payload;
        end
    end

endmodule

>>> rtl/tbi_out_reg.sv
// ----------------------------------------------------------------------------
// tbi_out_reg
// Result register that holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module tbi_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tbi_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output tbi_pkg::t_result o_res
);
    import tbi_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/tape_block_indexer.sv
// ----------------------------------------------------------------------------
// tape_block_indexer
// Walks a tape image byte by byte and reports the offset of every block ID.
// ----------------------------------------------------------------------------
// A byte is held in the input register; the core decodes it combinationally
// and its result is loaded into the result register, which drives the output.
// Throughput: one byte per cycle while the result side keeps up; the input
// register, the combinational decode and the result register set this figure.
// Reset (synchronous, active low) returns to the first block boundary at
// position zero and drops any held byte or result.
module tape_block_indexer #(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] block_offset, [39:32] block_id
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import tbi_pkg::*;

    t_item   in_item;
    t_item   core_item;
    t_result core_res;
    t_result out_res;
    logic    core_fire;
    logic    core_res_valid;
    logic    out_free;

    assign in_item = '{is_end: s_axis_tuser, data: s_axis_tdata};

    tbi_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_fire     (core_fire),
        .o_item     (core_item)
    );

    tbi_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (core_fire),
        .i_item      (core_item),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    tbi_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (core_res_valid),
        .i_res   (core_res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {out_res.id, out_res.offset};
    assign m_axis_tuser = out_res.status;

endmodule

>>> bench/tbi_index_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbi_index_check
// Watches both item channels of the tape block indexer. It walks its own copy
// of the tape layout for every accepted byte, queues the result that byte
// should produce and compares each delivered result with the oldest one.
// ----------------------------------------------------------------------------
module tbi_index_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  logic        i_s_tuser,    // [0] req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,    // [31:0] block_offset, [39:32] block_id
    input  logic [1:0]  i_m_tuser,    // [1:0] status
    output int          o_pending,
    output int          o_results,
    output int          o_fail_count
);

    typedef enum logic [2:0] {
        AT_BOUNDARY,
        IN_FIXED,
        IN_LENGTH,
        IN_PAYLOAD,
        STREAM_DONE,
        STREAM_BROKEN
    } t_walk;

    localparam int KindCount = 25;
    localparam int EntryBits = 18;
    localparam int PrintLimit = 40;

    // Each entry: ID, fixed bytes, length-field bytes, payload multiplier.
    localparam logic [KindCount*EntryBits-1:0] KIND_TABLE = {
        {8'h10, 5'd2,  3'd2, 2'd1}, {8'h11, 5'd15, 3'd3, 2'd1},
        {8'h12, 5'd4,  3'd0, 2'd1}, {8'h13, 5'd0,  3'd1, 2'd2},
        {8'h14, 5'd7,  3'd3, 2'd1}, {8'h15, 5'd5,  3'd3, 2'd1},
        {8'h18, 5'd0,  3'd4, 2'd1}, {8'h19, 5'd0,  3'd4, 2'd1},
        {8'h20, 5'd2,  3'd0, 2'd1}, {8'h21, 5'd0,  3'd1, 2'd1},
        {8'h22, 5'd0,  3'd0, 2'd1}, {8'h23, 5'd2,  3'd0, 2'd1},
        {8'h24, 5'd2,  3'd0, 2'd1}, {8'h25, 5'd0,  3'd0, 2'd1},
        {8'h26, 5'd0,  3'd2, 2'd2}, {8'h27, 5'd0,  3'd0, 2'd1},
        {8'h28, 5'd0,  3'd2, 2'd1}, {8'h2a, 5'd4,  3'd0, 2'd1},
        {8'h2b, 5'd5,  3'd0, 2'd1}, {8'h30, 5'd0,  3'd1, 2'd1},
        {8'h31, 5'd1,  3'd1, 2'd1}, {8'h32, 5'd0,  3'd2, 2'd1},
        {8'h33, 5'd0,  3'd1, 2'd3}, {8'h35, 5'd16, 3'd4, 2'd1},
        {8'h5a, 5'd9,  3'd0, 2'd1}
    };

    t_walk       walk         = AT_BOUNDARY;
    logic [31:0] position     = '0;
    logic [4:0]  fixed_left   = '0;
    logic [2:0]  length_left  = '0;
    logic [1:0]  length_lane  = '0;
    logic [31:0] length_acc   = '0;
    logic [1:0]  multiplier   = 2'd1;
    logic [31:0] payload_left = '0;

    tbi_pkg::t_result expected_results[$];
    int pending_count = 0;
    int results_seen  = 0;
    int mismatches    = 0;

    assign o_pending    = pending_count;
    assign o_results    = results_seen;
    assign o_fail_count = mismatches;

    function automatic tbi_pkg::t_kind layout_of(input logic [7:0] id);
        logic [EntryBits-1:0] entry;
        tbi_pkg::t_kind found;
        found = '0;
        for (int k = 0; k < KindCount; k++) begin
            entry = KIND_TABLE[k*EntryBits +: EntryBits];
            if (entry[17:10] == id) found = {1'b1, entry[9:0]};
        end
        return found;
    endfunction

    task automatic queue_result(input logic [1:0] status, input logic [31:0] offset,
                                input logic [7:0] id);
        tbi_pkg::t_result r;
        r.status = status;
        r.offset = offset;
        r.id     = id;
        expected_results.insert(expected_results.size(), r);
        pending_count++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PrintLimit)
            $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                     $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    // Advances the tape walk by one accepted item and queues its result, if any.
    task automatic index_byte(input logic is_end, input logic [7:0] data);
        tbi_pkg::t_kind kind;
        logic [33:0] product;
        case (walk)
            STREAM_BROKEN: begin
                queue_result(tbi_pkg::ST_ERROR, position, 8'd0);
            end
            STREAM_DONE: begin
                if (is_end) queue_result(tbi_pkg::ST_COMPLETE, position, 8'd0);
            end
            default: begin
                if (is_end) begin
                    if (walk == AT_BOUNDARY) begin
                        walk = STREAM_DONE;
                        queue_result(tbi_pkg::ST_COMPLETE, position, 8'd0);
                    end else begin
                        walk = STREAM_BROKEN;
                        queue_result(tbi_pkg::ST_ERROR, position, 8'd0);
                    end
                end else if (walk == AT_BOUNDARY) begin
                    kind = layout_of(data);
                    if (!kind.known) begin
                        // The position stays on the offending byte.
                        walk = STREAM_BROKEN;
                        queue_result(tbi_pkg::ST_ERROR, position, data);
                    end else begin
                        queue_result(tbi_pkg::ST_INDEXED, position, data);
                        position     = position + 32'd1;
                        fixed_left   = kind.fixed;
                        length_left  = kind.len_bytes;
                        length_lane  = '0;
                        length_acc   = '0;
                        multiplier   = kind.mult;
                        payload_left = '0;
                        if (kind.fixed != 0)
                            walk = IN_FIXED;
                        else
                            walk = (kind.len_bytes != 0) ? IN_LENGTH : AT_BOUNDARY;
                    end
                end else begin
                    position = position + 32'd1;
                    case (walk)
                        IN_FIXED: begin
                            fixed_left = fixed_left - 5'd1;
                            if (fixed_left == 0)
                                walk = (length_left != 0) ? IN_LENGTH : AT_BOUNDARY;
                        end
                        IN_LENGTH: begin
                            length_acc  = length_acc | ({24'd0, data} << (8 * length_lane));
                            length_lane = length_lane + 2'd1;
                            length_left = length_left - 3'd1;
                            if (length_left == 0) begin
                                product      = length_acc * multiplier;
                                payload_left = product[31:0];
                                walk = (payload_left != 0) ? IN_PAYLOAD : AT_BOUNDARY;
                            end
                        end
                        default: begin
                            payload_left = payload_left - 32'd1;
                            if (payload_left == 0) walk = AT_BOUNDARY;
                        end
                    endcase
                end
            end
        endcase
    endtask

    task automatic check_result();
        tbi_pkg::t_result want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, status", 32'(i_m_tuser), 32'd0);
        end else begin
            want = expected_results.pop_front();
            pending_count--;
            if (i_m_tuser != want.status)
                report_mismatch("status", 32'(i_m_tuser), 32'(want.status));
            if (i_m_tdata[31:0] != want.offset)
                report_mismatch("block_offset", i_m_tdata[31:0], want.offset);
            if (i_m_tdata[39:32] != want.id)
                report_mismatch("block_id", 32'(i_m_tdata[39:32]), 32'(want.id));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            walk          = AT_BOUNDARY;
            position      = '0;
            fixed_left    = '0;
            length_left   = '0;
            length_lane   = '0;
            length_acc    = '0;
            multiplier    = 2'd1;
            payload_left  = '0;
            pending_count = 0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) index_byte(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) check_result();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the tape block indexer a long tape image built from well-formed
// blocks with random content and random idling on both channels, including a
// long result-side hold. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    localparam int StreamItems    = 1270;
    localparam int HoldAfterItems = 500;
    localparam int LongHoldCycles = 400;
    localparam int TailItems      = 24;
    localparam int SettleCycles   = 20;

    // Both terminal states are sticky and reset is applied once, so every run
    // ends its stream in just one of these ways, drawn at random.
    typedef enum logic [1:0] {
        END_AT_BOUNDARY,
        END_ON_UNKNOWN_ID,
        END_INSIDE_BLOCK
    } t_ending;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int   pending;
    int   results;
    int   fail_count;
    int   items_sent    = 0;
    int   tx_gap_max    = 0;
    int   rx_gap_max    = 0;
    logic long_hold_req = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    tape_block_indexer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tbi_index_check u_index_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_pending    (pending),
        .o_results    (results),
        .o_fail_count (fail_count)
    );

    function automatic int draw_gap_limit();
        case ($urandom_range(2, 0))
            0: return 0;
            1: return 3;
            default: return 11;
        endcase
    endfunction

    function automatic logic [7:0] pick_known_id();
        logic [7:0] id;
        tbi_pkg::t_kind kind;
        do begin
            id   = 8'($urandom_range(255, 0));
            kind = tbi_pkg::kind_lookup(id);
        end while (!kind.known);
        return id;
    endfunction

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_item(input logic is_end, input logic [7:0] data);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= is_end;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // One complete block: ID, fixed bytes, length field, then the payload.
    task automatic send_block(input logic [7:0] id, input logic [31:0] length);
        tbi_pkg::t_kind kind;
        int payload;
        kind    = tbi_pkg::kind_lookup(id);
        payload = (kind.len_bytes != 0) ? length * kind.mult : 0;
        send_item(1'b0, id);
        repeat (kind.fixed) send_item(1'b0, 8'($urandom_range(255, 0)));
        for (int b = 0; b < kind.len_bytes; b++) send_item(1'b0, length[8*b +: 8]);
        repeat (payload) send_item(1'b0, 8'($urandom_range(255, 0)));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Result side.
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LongHoldCycles) @(posedge i_clk);
            end
            if ($urandom_range(9, 0) == 0) rx_gap_max = draw_gap_limit();
            gap = $urandom_range(rx_gap_max, 0);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Byte side and verdict.
    initial begin
        t_ending        ending;
        string          ending_text;
        tbi_pkg::t_kind kind;
        logic [7:0]     id;
        logic [7:0]     body_byte;
        logic [31:0]    length;
        int             body;
        logic           hold_fired;
        hold_fired = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Blocks with an empty remainder, a zero length, byte extremes in the
        // fixed part and an all-zero four-byte length field.
        send_block(8'h22, 32'd0);
        send_block(8'h27, 32'd0);
        send_block(8'h25, 32'd0);
        send_block(8'h13, 32'd0);
        send_block(8'h33, 32'd1);
        send_item(1'b0, 8'h31);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h20);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_block(8'h18, 32'd0);
        drain_results();

        while (items_sent < StreamItems) begin
            if (!hold_fired && items_sent >= HoldAfterItems) begin
                // Keep offering bytes while the result side stalls.
                hold_fired    = 1'b1;
                long_hold_req = 1'b1;
                tx_gap_max    = 0;
            end else if ($urandom_range(7, 0) == 0) begin
                tx_gap_max = draw_gap_limit();
            end
            if ($urandom_range(9, 0) == 0)
                length = $urandom_range(40, 10);
            else
                length = $urandom_range(9, 0);
            send_block(pick_known_id(), length);
        end

        ending = t_ending'($urandom_range(2, 0));
        case (ending)
            END_AT_BOUNDARY: begin
                ending_text = "at a block boundary";
                send_item(1'b1, 8'($urandom_range(255, 0)));
            end
            END_ON_UNKNOWN_ID: begin
                ending_text = "on an unknown block ID";
                do begin
                    id   = 8'($urandom_range(255, 0));
                    kind = tbi_pkg::kind_lookup(id);
                end while (kind.known);
                send_item(1'b0, id);
            end
            default: begin
                ending_text = "inside a block";
                do begin
                    id   = pick_known_id();
                    kind = tbi_pkg::kind_lookup(id);
                end while (kind.fixed + kind.len_bytes == 0);
                length = $urandom;
                body   = $urandom_range(kind.fixed + kind.len_bytes + 3, 0);
                send_item(1'b0, id);
                for (int b = 0; b < body; b++) begin
                    if (b >= kind.fixed && b < kind.fixed + kind.len_bytes)
                        body_byte = 8'(length >> (8 * (b - kind.fixed)));
                    else
                        body_byte = 8'($urandom_range(255, 0));
                    send_item(1'b0, body_byte);
                end
                send_item(1'b1, 8'($urandom_range(255, 0)));
            end
        endcase
        // Items after the stream has ended: repeated ends and stray bytes.
        repeat (TailItems)
            send_item(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));

        drain_results();
        repeat (SettleCycles) @(posedge i_clk);
        $display("Sent %0d items over %0d known block kinds with random gaps and a long hold.",
                 items_sent, 25);
        $display("Checked %0d results; the stream ended %s.", results, ending_text);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
